FILE: src/simple_register_machine_execute_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the register machine execute block
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIMPLE_REGISTER_MACHINE_EXECUTE_ASSERT_SVH
`define SIMPLE_REGISTER_MACHINE_EXECUTE_ASSERT_SVH

// Same-cycle implication: cons holds whenever ante holds.
`define SMRE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smre: same-cycle check failed");

// Next-cycle implication: cons holds in the cycle after ante.
`define SMRE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smre: next-cycle check failed");

`endif

FILE: src/smre_pkg.sv
// ----------------------------------------------------------------------------
// smre_pkg
// Shared types and constants of the register machine execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package smre_pkg;

  localparam int MemDepthDef  = 256;
  localparam int DataWidthDef = 32;
  localparam int RegCount     = 16;
  localparam int RegAw        = 4;

  typedef enum logic [3:0] {
    OP_LOAD  = 4'd1,
    OP_IMM   = 4'd2,
    OP_STORE = 4'd3,
    OP_MOVE  = 4'd4,
    OP_ADD   = 4'd5,
    OP_HALT  = 4'd12
  } opcode_e;

  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_HALT    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_REG  = 2'd1,
    WK_MEM  = 2'd2
  } write_kind_e;

  // Write-back control from execute to the storage
  typedef struct packed {
    logic       rf_we;
    logic       mem_we;
    logic [7:0] addr;
  } wb_ctrl_t;

  // One result transaction
  typedef struct packed {
    status_e     status;
    write_kind_e kind;
    logic [7:0]  target;
    logic [31:0] value;
  } result_t;

endpackage

`default_nettype wire

FILE: src/smre_ram.sv
// ----------------------------------------------------------------------------
// smre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smre_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/smre_exec.sv
// ----------------------------------------------------------------------------
// smre_exec
// Execute logic: decode one instruction, form the write-back and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module smre_exec
  import smre_pkg::*;
#(
  parameter int DataWidth = DataWidthDef,
  parameter int MemDepth  = MemDepthDef
) (
  input  wire logic [15:0]          instr_i,
  input  wire logic [DataWidth-1:0] rf_a_i,
  input  wire logic [DataWidth-1:0] rf_b_i,
  input  wire logic [DataWidth-1:0] mem_i,
  output      wb_ctrl_t             wb_o,
  output      logic [DataWidth-1:0] wb_data_o,
  output      result_t              res_o
);

  localparam logic [8:0] MemDepthW = 9'(MemDepth);

  logic [3:0]  reg_idx;
  logic [7:0]  operand;
  logic [3:0]  hi_idx;
  logic        in_range;
  status_e     status;
  logic [63:0] wide;

  assign reg_idx  = instr_i[11:8];
  assign operand  = instr_i[7:0];
  assign hi_idx   = instr_i[7:4];
  assign in_range = ({1'b0, operand} < MemDepthW);

  always_comb begin
    wb_o      = '0;
    wb_data_o = '0;
    status    = ST_EXEC;
    case (opcode_e'(instr_i[15:12]))
      OP_LOAD: begin
        wb_o.rf_we = 1'b1;
        wb_o.addr  = {4'd0, reg_idx};
        wb_data_o  = in_range ? mem_i : '1;
      end
      OP_IMM: begin
        wb_o.rf_we = 1'b1;
        wb_o.addr  = {4'd0, reg_idx};
        wb_data_o  = DataWidth'(operand);
      end
      OP_STORE: begin
        // Drop stores beyond the memory
        if (in_range) begin
          wb_o.mem_we = 1'b1;
          wb_o.addr   = operand;
          wb_data_o   = rf_a_i;
        end
      end
      OP_MOVE: begin
        if (reg_idx == 4'd0) begin
          wb_o.rf_we = 1'b1;
          wb_o.addr  = {4'd0, hi_idx};
          wb_data_o  = rf_a_i;
        end else begin
          status = ST_INVALID;
        end
      end
      OP_ADD: begin
        wb_o.rf_we = 1'b1;
        wb_o.addr  = {4'd0, reg_idx};
        wb_data_o  = rf_a_i + rf_b_i;
      end
      OP_HALT: begin
        status = ST_HALT;
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

  assign wide = 64'(wb_data_o);

  always_comb begin
    res_o.status = status;
    res_o.kind   = wb_o.rf_we ? WK_REG : (wb_o.mem_we ? WK_MEM : WK_NONE);
    res_o.target = wb_o.addr;
    res_o.value  = wide[31:0];
  end

endmodule

`default_nettype wire

FILE: src/simple_register_machine_execute.sv
// ----------------------------------------------------------------------------
// simple_register_machine_execute
// Executes one 16-bit register machine instruction per transaction.
// ----------------------------------------------------------------------------
// The block takes one instruction transaction per clock while stall_o is low
// and returns exactly one result transaction for each, in order. An
// instruction issues its reads of the register file and data memory
// (synchronous RAMs with registered read data) on the edge that accepts it,
// is executed and written back in the execute stage, and then sits in the
// output register, so valid_o rises as it is loaded there. The sustained
// rate is one instruction per cycle while no stall holds it, set by the
// single read-modify-write pass through the RAMs. A write made in write-back
// is forwarded to the next instruction that read the same entry in the same
// cycle. Reset clears both stores at once through per-entry valid bits (an
// entry never written reads as zero), so no clearing pass is needed and the
// block accepts instructions right after reset. stall_i from the consumer
// holds the output register and, through it, the execute stage.
`default_nettype none

module simple_register_machine_execute
  import smre_pkg::*;
#(
  parameter int MEM_DEPTH  = MemDepthDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output      logic               stall_o,
  input  wire logic [15:0]        instruction_word_i,
  output      logic               valid_o,
  input  wire logic               stall_i,
  output      logic [1:0]         status_o,
  output      logic [1:0]         write_kind_o,
  output      logic [7:0]         write_target_o,
  output      logic signed [31:0] written_value_o
);

  `include "simple_register_machine_execute_assert.svh"

  localparam int MemAw = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Port A of the register file reads the copy source, the add's first
  // operand or the store source; port B always reads the add's second one.
  function automatic logic [RegAw-1:0] rf_a_sel(input logic [15:0] word);
    logic [RegAw-1:0] sel;
    case (opcode_e'(word[15:12]))
      OP_MOVE: sel = word[3:0];
      OP_ADD:  sel = word[7:4];
      default: sel = word[11:8];
    endcase
    return sel;
  endfunction

  // Handshake and stage control
  logic accept;
  logic out_ld;
  logic s1_adv;

  // Execute stage
  logic        s1_valid_q;
  logic [15:0] s1_instr_q;
  logic        s1_a_vld_q;
  logic        s1_b_vld_q;
  logic        s1_m_vld_q;

  // Entry valid bits: an entry never written reads as zero
  logic [RegCount-1:0]  rf_vld_q;
  logic [MEM_DEPTH-1:0] mem_vld_q;

  // Last write to each store, for forwarding
  logic                  lw_rf_vld_q;
  logic [RegAw-1:0]      lw_rf_addr_q;
  logic [DATA_WIDTH-1:0] lw_rf_data_q;
  logic                  lw_mem_vld_q;
  logic [MemAw-1:0]      lw_mem_addr_q;
  logic [DATA_WIDTH-1:0] lw_mem_data_q;

  // Read side
  logic [RegAw-1:0]      in_a_addr;
  logic [RegAw-1:0]      in_b_addr;
  logic [MemAw-1:0]      in_m_addr;
  logic [RegAw-1:0]      s1_a_addr;
  logic [RegAw-1:0]      s1_b_addr;
  logic [MemAw-1:0]      s1_m_addr;
  logic [DATA_WIDTH-1:0] rf_a_rdata;
  logic [DATA_WIDTH-1:0] rf_b_rdata;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [DATA_WIDTH-1:0] rf_a_val;
  logic [DATA_WIDTH-1:0] rf_b_val;
  logic [DATA_WIDTH-1:0] mem_val;

  // Write-back
  wb_ctrl_t              exec_wb;
  logic [DATA_WIDTH-1:0] exec_wb_data;
  result_t               exec_res;
  logic                  rf_we;
  logic                  mem_we;

  // Output register
  logic    out_valid_q;
  result_t out_q;

  // --------------------------------------------------------------------------
  // Handshake: the execute stage moves on whenever the output register is
  // free or being emptied; a new transaction enters while the stage is empty or moving on.
  // --------------------------------------------------------------------------
  assign out_ld  = !out_valid_q || !stall_i;
  assign s1_adv  = s1_valid_q && out_ld;
  assign stall_o = s1_valid_q && !out_ld;
  assign accept  = valid_i && !stall_o;

  // --------------------------------------------------------------------------
  // Read stage: address the RAMs straight from the incoming instruction.
  // --------------------------------------------------------------------------
  assign in_a_addr = rf_a_sel(instruction_word_i);
  assign in_b_addr = instruction_word_i[3:0];
  assign in_m_addr = instruction_word_i[MemAw-1:0];

  smre_ram #(
    .Width (DATA_WIDTH),
    .Depth (RegCount)
  ) u_rf_ram_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (exec_wb.addr[RegAw-1:0]),
    .wdata_i (exec_wb_data),
    .re_i    (accept),
    .raddr_i (in_a_addr),
    .rdata_o (rf_a_rdata)
  );

  // Second copy of the register file gives the add its second read port
  smre_ram #(
    .Width (DATA_WIDTH),
    .Depth (RegCount)
  ) u_rf_ram_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (exec_wb.addr[RegAw-1:0]),
    .wdata_i (exec_wb_data),
    .re_i    (accept),
    .raddr_i (in_b_addr),
    .rdata_o (rf_b_rdata)
  );

  smre_ram #(
    .Width (DATA_WIDTH),
    .Depth (MEM_DEPTH)
  ) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (exec_wb.addr[MemAw-1:0]),
    .wdata_i (exec_wb_data),
    .re_i    (accept),
    .raddr_i (in_m_addr),
    .rdata_o (mem_rdata)
  );

  // Capture the instruction and the valid bits of the entries it reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_a_vld_q <= 1'b0;
      s1_b_vld_q <= 1'b0;
      s1_m_vld_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_a_vld_q <= rf_vld_q[in_a_addr];
      s1_b_vld_q <= rf_vld_q[in_b_addr];
      s1_m_vld_q <= mem_vld_q[in_m_addr];
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_instr_q <= instruction_word_i;
    end
  end

  // --------------------------------------------------------------------------
  // Execute stage: fix up the read data, then decode and write back.
  // The last write landed on the same edge as the read, so the RAM still
  // returned the old word; take the forwarded one instead.
  // --------------------------------------------------------------------------
  assign s1_a_addr = rf_a_sel(s1_instr_q);
  assign s1_b_addr = s1_instr_q[3:0];
  assign s1_m_addr = s1_instr_q[MemAw-1:0];

  assign rf_a_val = (lw_rf_vld_q && lw_rf_addr_q == s1_a_addr) ? lw_rf_data_q :
                    (s1_a_vld_q ? rf_a_rdata : '0);
  assign rf_b_val = (lw_rf_vld_q && lw_rf_addr_q == s1_b_addr) ? lw_rf_data_q :
                    (s1_b_vld_q ? rf_b_rdata : '0);
  assign mem_val  = (lw_mem_vld_q && lw_mem_addr_q == s1_m_addr) ? lw_mem_data_q :
                    (s1_m_vld_q ? mem_rdata : '0);

  smre_exec #(
    .DataWidth (DATA_WIDTH),
    .MemDepth  (MEM_DEPTH)
  ) u_exec (
    .instr_i   (s1_instr_q),
    .rf_a_i    (rf_a_val),
    .rf_b_i    (rf_b_val),
    .mem_i     (mem_val),
    .wb_o      (exec_wb),
    .wb_data_o (exec_wb_data),
    .res_o     (exec_res)
  );

  // Commit the write only as the instruction leaves the stage
  assign rf_we  = s1_adv && exec_wb.rf_we;
  assign mem_we = s1_adv && exec_wb.mem_we;

  // Mark written entries and remember the latest write of each store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q     <= '0;
      mem_vld_q    <= '0;
      lw_rf_vld_q  <= 1'b0;
      lw_mem_vld_q <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_q[exec_wb.addr[RegAw-1:0]] <= 1'b1;
        lw_rf_vld_q                       <= 1'b1;
      end
      if (mem_we) begin
        mem_vld_q[exec_wb.addr[MemAw-1:0]] <= 1'b1;
        lw_mem_vld_q                       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      lw_rf_addr_q <= exec_wb.addr[RegAw-1:0];
      lw_rf_data_q <= exec_wb_data;
    end
    if (mem_we) begin
      lw_mem_addr_q <= exec_wb.addr[MemAw-1:0];
      lw_mem_data_q <= exec_wb_data;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: load as the execute stage advances, drop once taken.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= exec_res;
    end
  end

  assign valid_o         = out_valid_q;
  assign status_o        = out_q.status;
  assign write_kind_o    = out_q.kind;
  assign write_target_o  = out_q.target;
  assign written_value_o = out_q.value;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // One instruction writes at most one of the two stores
  `SMRE_ASSERT_IMP(a_one_store_written, rf_we, !mem_we)
  // A store never writes beyond the memory
  `SMRE_ASSERT_IMP(a_mem_write_in_range, mem_we, ({1'b0, exec_wb.addr} < 9'(MEM_DEPTH)))
  // An instruction leaving execute shows up in the output register
  `SMRE_ASSERT_NXT(a_adv_fills_output, s1_adv, out_valid_q)
  // A stalled execute stage keeps its instruction
  `SMRE_ASSERT_NXT(a_stall_holds_stage, stall_o, s1_valid_q && $stable(s1_instr_q))

endmodule

`default_nettype wire
